@@ rtl/core/mmm_pkg.sv @@
// shared types, constants and helpers of the multirotor motor mixer
// depends on nothing; used by every file of the mixer
package mmm_pkg;

    // default motor capacity
    localparam int MAX_MOTORS_DEF = 8;

    // fixed field widths
    localparam int CMD_W   = 16;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int TABLE_W = 64;
    localparam int MASK_W  = 8;
    localparam int VAL_W   = 20;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_CNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_TABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_TABLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_MASK    = 3'd5;

    // reset values
    localparam logic [CMD_W-1:0] OUTPUT_MAX_RST = 16'd32767;
    localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [CMD_W-1:0] U16_MAX = 16'hFFFF;

    // per-cycle control of the shared mix unit
    typedef struct packed {
        logic [IDX_W-1:0] mul_idx;   // motor whose position feeds the multiplier
        logic             sel_y;     // 0: -roll * x, 1: pitch * y
        logic             acc_load;  // capture the first product
        logic             mix_load;  // sum, floor shift and yaw term
        logic             cw;        // motor spins clockwise
    } t_mix_ctrl;

    // signed q1.6 position of one motor from a packed table
    function automatic logic signed [7:0] table_byte(input logic [TABLE_W-1:0] tbl,
                                                     input logic [IDX_W-1:0] idx);
        return tbl[{idx, 3'b000} +: 8];
    endfunction

    // saturate a signed value to 0..65535
    function automatic logic [CMD_W-1:0] sat_u16(input logic signed [VAL_W:0] v);
        logic [CMD_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(VAL_W-CMD_W+1){1'b0}}, U16_MAX})) begin
            res = U16_MAX;
        end else begin
            res = v[CMD_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/multirotor_motor_mixer.sv @@
// top level of the multirotor motor mixer: registers, sequencer, motor store, output stage
// depends on mmm_pkg and mmm_mix_unit
//
// usage
//   input channel: throttle, yaw, pitch and roll of one command set; a request is
//   taken when i_in_valid is high and o_in_stall is low. o_in_stall stays high from
//   a taken request until the last motor result of that set has been delivered.
//   output channel: one result per motor in index order (motor 0 first), with
//   o_last on the final motor; a result is delivered when o_out_valid is high and
//   i_out_stall is low. a command set with zero motors in use gives no result.
//   configuration channel: i_cfg_index / i_cfg_data written when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high; indexes past the list are
//   ignored. write only while the block is idle.
//   flow: one shared multiplier forms the x and then the y product of each motor, so
//   the mix pass handles the motors one after another; the S_ADJ state then finds the
//   excess over output_max, and the output pass reads the motor store ahead of the
//   result register and gives one result per cycle while i_out_stall is low.
//   a stalled result holds its value; the read ahead waits behind it.
//   reset (synchronous, active low) restores the register defaults and empties
//   the output stage; the block is ready in the cycle after reset.
module multirotor_motor_mixer #(
    parameter int MAX_MOTORS = mmm_pkg::MAX_MOTORS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command request
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mmm_pkg::CMD_W-1:0]          i_throttle,
    input  logic signed [mmm_pkg::CMD_W-1:0]   i_yaw_cmd,
    input  logic signed [mmm_pkg::CMD_W-1:0]   i_pitch_cmd,
    input  logic signed [mmm_pkg::CMD_W-1:0]   i_roll_cmd,
    // motor results
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mmm_pkg::IDX_W-1:0]          o_motor_index,
    output logic [mmm_pkg::CMD_W-1:0]          o_motor_output,
    output logic                               o_last,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mmm_pkg::TABLE_W-1:0]        i_cfg_data
);

    localparam int ADDR_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MIX  = 2'd1;
    localparam logic [1:0] S_ADJ  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;

    // configuration registers
    logic [mmm_pkg::CMD_W-1:0]         r_output_min;
    logic [mmm_pkg::CMD_W-1:0]         r_output_max;
    logic [mmm_pkg::CNT_W-1:0]         r_motor_count;
    logic [mmm_pkg::TABLE_W-1:0]       r_x_table;
    logic [mmm_pkg::TABLE_W-1:0]       r_y_table;
    logic [mmm_pkg::MASK_W-1:0]        r_cw_mask;

    // per request operands
    logic [mmm_pkg::CNT_W-1:0]         r_n;
    logic signed [mmm_pkg::CMD_W:0]    r_neg_roll;
    logic signed [mmm_pkg::CMD_W-1:0]  r_pitch;
    logic signed [mmm_pkg::CMD_W-1:0]  r_yaw;
    logic [mmm_pkg::CMD_W-1:0]         r_dyn;
    logic [mmm_pkg::CMD_W-1:0]         r_base;

    logic [mmm_pkg::CNT_W:0]           r_c;
    logic signed [mmm_pkg::VAL_W-1:0]  r_largest;
    logic [mmm_pkg::VAL_W-1:0]         r_excess;
    logic signed [mmm_pkg::VAL_W-1:0]  r_mem [MAX_MOTORS];
    logic signed [mmm_pkg::VAL_W-1:0]  r_rd;
    logic                              r_rd_v;
    logic [mmm_pkg::CNT_W-1:0]         r_rk;
    logic [mmm_pkg::CNT_W-1:0]         r_ld;
    logic                              r_out_valid;
    logic [mmm_pkg::IDX_W-1:0]         r_out_idx;
    logic [mmm_pkg::CMD_W-1:0]         r_out_val;
    logic                              r_out_last;

    logic                              in_take;
    logic                              out_take;
    logic                              rd_fire;
    logic                              ld_fire;
    logic [mmm_pkg::CNT_W-1:0]         n_eff;
    logic [mmm_pkg::CMD_W-1:0]         low_room;
    logic [mmm_pkg::CMD_W-1:0]         half_span;
    logic [mmm_pkg::CNT_W-1:0]         c_half;
    logic [mmm_pkg::CNT_W-1:0]         c_prev;
    logic                              mix_done;
    logic                              wr_en;
    logic                              cfg_take;
    mmm_pkg::t_mix_ctrl                mix_ctrl;
    logic signed [mmm_pkg::VAL_W-1:0]  mix_value;
    logic signed [mmm_pkg::VAL_W:0]    adj_value;

    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_min  <= '0;
            r_output_max  <= mmm_pkg::OUTPUT_MAX_RST;
            r_motor_count <= '0;
            r_x_table     <= '0;
            r_y_table     <= '0;
            r_cw_mask     <= '0;
        end else if (cfg_take) begin
            unique case (i_cfg_index)
                mmm_pkg::CFG_OUTPUT_MIN: r_output_min  <= i_cfg_data[mmm_pkg::CMD_W-1:0];
                mmm_pkg::CFG_OUTPUT_MAX: r_output_max  <= i_cfg_data[mmm_pkg::CMD_W-1:0];
                mmm_pkg::CFG_MOTOR_CNT:  r_motor_count <= i_cfg_data[mmm_pkg::CNT_W-1:0];
                mmm_pkg::CFG_X_TABLE:    r_x_table     <= i_cfg_data;
                mmm_pkg::CFG_Y_TABLE:    r_y_table     <= i_cfg_data;
                mmm_pkg::CFG_CW_MASK:    r_cw_mask     <= i_cfg_data[mmm_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // motor count limit, dynamic range and base level of a new request
    always_comb begin
        n_eff = (r_motor_count > mmm_pkg::CNT_W'(MAX_MOTORS)) ?
                mmm_pkg::CNT_W'(MAX_MOTORS) : r_motor_count;
        low_room  = (i_throttle > r_output_min) ? (i_throttle - r_output_min) : '0;
        half_span = (r_output_max > r_output_min) ?
                    ((r_output_max - r_output_min) >> 1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_n        <= n_eff;
            r_neg_roll <= -{i_roll_cmd[mmm_pkg::CMD_W-1], i_roll_cmd};
            r_pitch    <= i_pitch_cmd;
            r_yaw      <= i_yaw_cmd;
            r_dyn      <= (low_room < half_span) ? low_room : half_span;
            r_base     <= (i_throttle > r_output_min) ? i_throttle : r_output_min;
        end
    end

    // mix pass schedule: even cycles x product, odd cycles y product
    always_comb begin
        c_half   = r_c[mmm_pkg::CNT_W:1];
        c_prev   = c_half - 4'd1;
        mix_done = (r_c == {r_n, 1'b1});
        mix_ctrl.mul_idx  = c_half[mmm_pkg::IDX_W-1:0];
        mix_ctrl.sel_y    = r_c[0];
        mix_ctrl.acc_load = (r_state == S_MIX) && r_c[0];
        mix_ctrl.mix_load = (r_state == S_MIX) && !r_c[0] && (c_half != '0);
        mix_ctrl.cw       = r_cw_mask[c_prev[mmm_pkg::IDX_W-1:0]];
        wr_en = (r_state == S_MIX) && r_c[0] && (c_half != '0);
    end

    mmm_mix_unit u_mix (
        .i_clk      (i_clk),
        .i_ctrl     (mix_ctrl),
        .i_neg_roll (r_neg_roll),
        .i_pitch    (r_pitch),
        .i_yaw      (r_yaw),
        .i_x_table  (r_x_table),
        .i_y_table  (r_y_table),
        .i_dyn      (r_dyn),
        .i_base     (r_base),
        .o_value    (mix_value)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_take && (n_eff != '0)) n_state = S_MIX;
            S_MIX:  if (mix_done) n_state = S_ADJ;
            S_ADJ:  n_state = S_OUT;
            S_OUT:  if (out_take && r_out_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // mix cycle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (in_take || (r_state != S_MIX)) begin
            r_c <= '0;
        end else begin
            r_c <= r_c + 5'd1;
        end
    end

    // motor store and largest value
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[c_prev[ADDR_W-1:0]] <= mix_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest <= mmm_pkg::MOST_NEG;
        end else if (in_take) begin
            r_largest <= mmm_pkg::MOST_NEG;
        end else if (wr_en && (mix_value > r_largest)) begin
            r_largest <= mix_value;
        end
    end

    // excess over the top of the output range
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADJ) begin
            if (r_largest > $signed({{(mmm_pkg::VAL_W-mmm_pkg::CMD_W){1'b0}}, r_output_max}))
            begin
                r_excess <= r_largest
                          - {{(mmm_pkg::VAL_W-mmm_pkg::CMD_W){1'b0}}, r_output_max};
            end else begin
                r_excess <= '0;
            end
        end
    end

    // output pass: read ahead one entry, load the result register when free
    assign ld_fire = (r_state == S_OUT) && r_rd_v && (!r_out_valid || out_take);
    assign rd_fire = (r_state == S_OUT) && (r_rk < r_n) && (!r_rd_v || ld_fire);
    assign adj_value = {r_rd[mmm_pkg::VAL_W-1], r_rd} - {1'b0, r_excess};

    always_ff @(posedge i_clk) begin
        if (rd_fire) begin
            r_rd <= r_mem[r_rk[ADDR_W-1:0]];
        end
        if (ld_fire) begin
            r_out_idx  <= r_ld[mmm_pkg::IDX_W-1:0];
            r_out_val  <= mmm_pkg::sat_u16(adj_value);
            r_out_last <= (r_ld == (r_n - 4'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v      <= 1'b0;
            r_rk        <= '0;
            r_ld        <= '0;
            r_out_valid <= 1'b0;
        end else if (r_state != S_OUT) begin
            r_rd_v      <= 1'b0;
            r_rk        <= '0;
            r_ld        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_fire) begin
                r_rd_v <= 1'b1;
                r_rk   <= r_rk + 4'd1;
            end else if (ld_fire) begin
                r_rd_v <= 1'b0;
            end
            if (ld_fire) begin
                r_ld        <= r_ld + 4'd1;
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motor_index  = r_out_idx;
    assign o_motor_output = r_out_val;
    assign o_last         = r_out_last;

endmodule

@@ rtl/core/mmm_mix_unit.sv @@
// shared multiply, accumulate and clamp datapath of the motor mixer
// depends on mmm_pkg; driven cycle by cycle by the sequencer in the top level
module mmm_mix_unit (
    input  logic                                  i_clk,
    input  mmm_pkg::t_mix_ctrl                    i_ctrl,
    input  logic signed [mmm_pkg::CMD_W:0]        i_neg_roll,
    input  logic signed [mmm_pkg::CMD_W-1:0]      i_pitch,
    input  logic signed [mmm_pkg::CMD_W-1:0]      i_yaw,
    input  logic [mmm_pkg::TABLE_W-1:0]           i_x_table,
    input  logic [mmm_pkg::TABLE_W-1:0]           i_y_table,
    input  logic [mmm_pkg::CMD_W-1:0]             i_dyn,
    input  logic [mmm_pkg::CMD_W-1:0]             i_base,
    output logic signed [mmm_pkg::VAL_W-1:0]      o_value
);

    logic signed [mmm_pkg::CMD_W:0]   mul_a;
    logic signed [7:0]                mul_b;
    logic signed [24:0]               mul_p;
    logic signed [24:0]               r_prod;
    logic signed [24:0]               r_acc;
    logic signed [25:0]               sum;
    logic signed [mmm_pkg::VAL_W-1:0] floor_term;
    logic signed [mmm_pkg::VAL_W:0]   yaw_ext;
    logic signed [mmm_pkg::VAL_W:0]   n_mix;
    logic signed [mmm_pkg::VAL_W:0]   r_mix;
    logic signed [mmm_pkg::VAL_W:0]   dyn_pos;
    logic signed [mmm_pkg::VAL_W:0]   dyn_neg;
    logic signed [mmm_pkg::VAL_W:0]   clamped;
    logic signed [mmm_pkg::VAL_W:0]   with_base;

    // shared multiplier: one position product per cycle
    always_comb begin
        if (i_ctrl.sel_y) begin
            mul_a = {i_pitch[mmm_pkg::CMD_W-1], i_pitch};
            mul_b = mmm_pkg::table_byte(i_y_table, i_ctrl.mul_idx);
        end else begin
            mul_a = i_neg_roll;
            mul_b = mmm_pkg::table_byte(i_x_table, i_ctrl.mul_idx);
        end
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_ctrl.acc_load) begin
            r_acc <= r_prod;
        end
    end

    // sum of both products, floor division by 64, then yaw by spin direction
    always_comb begin
        sum        = {r_acc[24], r_acc} + {r_prod[24], r_prod};
        floor_term = sum[25:6];
        yaw_ext    = {{(mmm_pkg::VAL_W+1-mmm_pkg::CMD_W){i_yaw[mmm_pkg::CMD_W-1]}}, i_yaw};
        if (i_ctrl.cw) begin
            n_mix = {floor_term[mmm_pkg::VAL_W-1], floor_term} + yaw_ext;
        end else begin
            n_mix = {floor_term[mmm_pkg::VAL_W-1], floor_term} - yaw_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mix_load) begin
            r_mix <= n_mix;
        end
    end

    // clamp to the dynamic range and lift by the base level
    always_comb begin
        dyn_pos = {{(mmm_pkg::VAL_W+1-mmm_pkg::CMD_W){1'b0}}, i_dyn};
        dyn_neg = -dyn_pos;
        if (r_mix > dyn_pos) begin
            clamped = dyn_pos;
        end else if (r_mix < dyn_neg) begin
            clamped = dyn_neg;
        end else begin
            clamped = r_mix;
        end
        with_base = clamped + {{(mmm_pkg::VAL_W+1-mmm_pkg::CMD_W){1'b0}}, i_base};
        o_value   = with_base[mmm_pkg::VAL_W-1:0];
    end

endmodule

@@ rtl/core/mmm_checker.sv @@
// port-level checks of the multirotor motor mixer, bound to the top level
// depends on mmm_pkg and multirotor_motor_mixer
module mmm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [mmm_pkg::IDX_W-1:0]         o_motor_index,
    input logic [mmm_pkg::CMD_W-1:0]         o_motor_output,
    input logic                              o_last
);

    // results only show up while a request is being worked on
    a_busy_while_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result valid while input side is ready");

    // nothing follows the last result of a set
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_out_valid)
        else $error("result valid right after the last one");

    // results of one set stream back to back in motor order
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
            (o_out_valid && (o_motor_index == $past(o_motor_index) + 3'd1)))
        else $error("motor index did not advance by one");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_motor_output) && $stable(o_motor_index)))
        else $error("stalled result changed");

endmodule

bind multirotor_motor_mixer mmm_checker u_mmm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_motor_index  (o_motor_index),
    .o_motor_output (o_motor_output),
    .o_last         (o_last)
);

@@ dv/tb.sv @@
// testbench of the multirotor motor mixer: directed table, then randomized phases
// depends on mmm_pkg and the top level multirotor_motor_mixer
// every motor result is checked in order against an in-bench mixing predictor or a typed expected value
`timescale 1ns / 1ps

module tb;
    import mmm_pkg::*;

    // write indexes past the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // settle time after the last result, longer than a full request takes
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [TABLE_W-1:0]   reg_data;
        logic [CMD_W-1:0]     thr;
        logic [CMD_W-1:0]     yaw;
        logic [CMD_W-1:0]     pitch;
        logic [CMD_W-1:0]     roll;
        bit                   typed;
        logic [CMD_W-1:0]     typed_out;
    } stim_row_t;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [CMD_W-1:0] drive;
        logic             last;
    } motor_res_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [CMD_W-1:0]          i_throttle = '0;
    logic signed [CMD_W-1:0]   i_yaw_cmd = '0;
    logic signed [CMD_W-1:0]   i_pitch_cmd = '0;
    logic signed [CMD_W-1:0]   i_roll_cmd = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [IDX_W-1:0]          o_motor_index;
    logic [CMD_W-1:0]          o_motor_output;
    logic                      o_last;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [TABLE_W-1:0]        i_cfg_data = '0;

    // mirror of the configuration registers, reset values
    logic [CMD_W-1:0]   m_min = '0;
    logic [CMD_W-1:0]   m_max = OUTPUT_MAX_RST;
    logic [CNT_W-1:0]   m_cnt = '0;
    logic [TABLE_W-1:0] m_x = '0;
    logic [TABLE_W-1:0] m_y = '0;
    logic [MASK_W-1:0]  m_cw = '0;

    motor_res_t       pending_drives[$];
    stim_row_t        stim_rows[$];
    int               mismatch_cnt = 0;
    int               send_pct = 0;
    int               stall_pct = 0;
    bit               cmd_typed = 1'b0;
    logic [CMD_W-1:0] cmd_typed_out = '0;

    multirotor_motor_mixer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_throttle     (i_throttle),
        .i_yaw_cmd      (i_yaw_cmd),
        .i_pitch_cmd    (i_pitch_cmd),
        .i_roll_cmd     (i_roll_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_motor_index  (o_motor_index),
        .o_motor_output (o_motor_output),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // mix one command set with the mirrored registers, queue the motor drives
    function automatic void mix_command(input logic [CMD_W-1:0] thr,
                                        input logic signed [CMD_W-1:0] yaw,
                                        input logic signed [CMD_W-1:0] pitch,
                                        input logic signed [CMD_W-1:0] roll);
        int         n;
        int         lo_room;
        int         half_span;
        int         dyn;
        int         base;
        int         peak;
        int         s;
        int         v;
        int         vals[8];
        motor_res_t r;
        n = (m_cnt > MAX_MOTORS_DEF) ? MAX_MOTORS_DEF : int'(m_cnt);
        lo_room = (thr > m_min) ? int'(thr) - int'(m_min) : 0;
        half_span = (m_max > m_min) ? (int'(m_max) - int'(m_min)) / 2 : 0;
        dyn = (lo_room < half_span) ? lo_room : half_span;
        base = (thr > m_min) ? int'(thr) : int'(m_min);
        peak = -524288;
        for (int i = 0; i < n; i++) begin
            s = -int'(roll) * int'($signed(m_x[8*i +: 8]))
                + int'(pitch) * int'($signed(m_y[8*i +: 8]));
            // arithmetic shift rounds toward minus infinity
            v = s >>> 6;
            if (m_cw[i]) v = v + int'(yaw);
            else v = v - int'(yaw);
            if (v > dyn) v = dyn;
            if (v < -dyn) v = -dyn;
            v = v + base;
            vals[i] = v;
            if (v > peak) peak = v;
        end
        // pull everything down by the excess over output_max
        if (n > 0 && peak > int'(m_max)) begin
            for (int i = 0; i < n; i++) vals[i] = vals[i] - (peak - int'(m_max));
        end
        for (int i = 0; i < n; i++) begin
            r.idx = i[IDX_W-1:0];
            if (vals[i] < 0) r.drive = '0;
            else if (vals[i] > 65535) r.drive = U16_MAX;
            else r.drive = vals[i][CMD_W-1:0];
            r.last = (i == n - 1);
            pending_drives.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // observe requests, register writes and results at the rising edge
    always @(posedge i_clk) begin
        motor_res_t want;
        int         n;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_drives.size() == 0) begin
                    report_mismatch("unexpected result for motor", o_motor_index, -1);
                end else begin
                    want = pending_drives.pop_front();
                    if (o_motor_index !== want.idx)
                        report_mismatch("motor_index", o_motor_index, want.idx);
                    if (o_motor_output !== want.drive)
                        report_mismatch("motor_output", o_motor_output, want.drive);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MIN: m_min = i_cfg_data[CMD_W-1:0];
                    CFG_OUTPUT_MAX: m_max = i_cfg_data[CMD_W-1:0];
                    CFG_MOTOR_CNT:  m_cnt = i_cfg_data[CNT_W-1:0];
                    CFG_X_TABLE:    m_x = i_cfg_data;
                    CFG_Y_TABLE:    m_y = i_cfg_data;
                    CFG_CW_MASK:    m_cw = i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                if (cmd_typed) begin
                    n = (m_cnt > MAX_MOTORS_DEF) ? MAX_MOTORS_DEF : int'(m_cnt);
                    for (int i = 0; i < n; i++) begin
                        want.idx = i[IDX_W-1:0];
                        want.drive = cmd_typed_out;
                        want.last = (i == n - 1);
                        pending_drives.push_back(want);
                    end
                end else begin
                    mix_command(i_throttle, i_yaw_cmd, i_pitch_cmd, i_roll_cmd);
                end
            end
        end
    end

    // present one command request and hold it until taken
    task automatic send_command(input logic [CMD_W-1:0] thr, input logic [CMD_W-1:0] yaw,
                                input logic [CMD_W-1:0] pitch, input logic [CMD_W-1:0] roll,
                                input bit typed, input logic [CMD_W-1:0] typed_out);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_throttle = thr;
        i_yaw_cmd = yaw;
        i_pitch_cmd = pitch;
        i_roll_cmd = roll;
        cmd_typed = typed;
        cmd_typed_out = typed_out;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop requests, wait for every result, then let the block go idle
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CMD_W-1:0] mn, input logic [CMD_W-1:0] mx,
                                 input logic [CNT_W-1:0] cnt, input logic [TABLE_W-1:0] xt,
                                 input logic [TABLE_W-1:0] yt, input logic [MASK_W-1:0] cw);
        write_reg(CFG_OUTPUT_MIN, TABLE_W'(mn));
        write_reg(CFG_OUTPUT_MAX, TABLE_W'(mx));
        write_reg(CFG_MOTOR_CNT, TABLE_W'(cnt));
        write_reg(CFG_X_TABLE, xt);
        write_reg(CFG_Y_TABLE, yt);
        write_reg(CFG_CW_MASK, TABLE_W'(cw));
    endtask

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin send_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_pct = 48; stall_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  stall_pct = 48; end
            default:   begin send_pct = 23; stall_pct = 23; end
        endcase
    endtask

    function automatic void add_cmd(input int thr, input int yaw, input int pitch, input int roll,
                                    input bit typed, input int typed_out);
        stim_row_t r;
        r.kind = ROW_CMD;
        r.reg_idx = '0;
        r.reg_data = '0;
        r.thr = thr[CMD_W-1:0];
        r.yaw = yaw[CMD_W-1:0];
        r.pitch = pitch[CMD_W-1:0];
        r.roll = roll[CMD_W-1:0];
        r.typed = typed;
        r.typed_out = typed_out[CMD_W-1:0];
        stim_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [TABLE_W-1:0] data);
        stim_row_t r;
        r = '{ROW_CFG, idx, data, '0, '0, '0, '0, 1'b0, '0};
        stim_rows.push_back(r);
    endfunction

    function automatic logic [TABLE_W-1:0] rand_table();
        case ($urandom_range(0, 7))
            0: return 64'h7F7F_7F7F_7F7F_7F7F;
            1: return 64'h8080_8080_8080_8080;
            2: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // half full range, half small signed commands
    function automatic logic [CMD_W-1:0] rand_cmd();
        int v;
        if ($urandom_range(0, 1)) v = $urandom_range(0, 65535);
        else v = int'($urandom_range(0, 2048)) - 1024;
        return v[CMD_W-1:0];
    endfunction

    initial begin
        stim_row_t        row;
        bit               need_drain;
        logic [CMD_W-1:0] ph_min;
        logic [CMD_W-1:0] ph_max;
        logic [CNT_W-1:0] ph_cnt;
        logic [MASK_W-1:0] ph_cw;
        int               t;
        int               hi;
        int               lo;

        // reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        // reset settings have no motors in use, so nothing comes back
        add_cmd(1000, 0, 0, 0, 1'b0, 0);
        add_cfg(CFG_MOTOR_CNT, 64'd4);
        // zero positions: every motor follows throttle, limited by output_max
        add_cmd(0, 0, 0, 0, 1'b1, 0);
        add_cmd(65535, 0, 0, 0, 1'b1, 32767);
        add_cmd(16384, 0, 0, 0, 1'b1, 16384);
        // pure yaw against counter-clockwise motors, clamped to the dynamic range
        add_cmd(16384, 32767, 0, 0, 1'b1, 1);
        add_cmd(16384, -32768, 0, 0, 1'b1, 32767);
        add_cfg(CFG_X_TABLE, 64'h40C0_40C0_807F_FF01);
        add_cfg(CFG_Y_TABLE, 64'h7F80_40C0_C0C0_4040);
        add_cfg(CFG_CW_MASK, 64'hA5);
        // attitude term rounding toward minus infinity
        add_cmd(20000, 0, 0, 1, 1'b0, 0);
        add_cmd(20000, 0, 0, -1, 1'b0, 0);
        add_cmd(20000, 0, -1, 0, 1'b0, 0);
        // command extremes
        add_cmd(32768, -32768, 32767, -32768, 1'b0, 0);
        add_cmd(32768, 32767, -32768, 32767, 1'b0, 0);
        add_cmd(65535, 32767, 32767, 32767, 1'b0, 0);
        // motor count above capacity acts as full capacity
        add_cfg(CFG_MOTOR_CNT, 64'd15);
        add_cmd(30000, 100, -200, 300, 1'b0, 0);
        add_cfg(CFG_MOTOR_CNT, 64'd8);
        add_cmd(0, -32768, -32768, -32768, 1'b0, 0);
        // writes past the register list leave everything unchanged
        add_cfg(CFG_SPARE_6, '1);
        add_cfg(CFG_SPARE_7, 64'h0123_4567_89AB_CDEF);
        add_cmd(12345, 5, 6, 7, 1'b0, 0);
        // min above max: no dynamic range, every motor sits at output_max
        add_cfg(CFG_OUTPUT_MIN, 64'd20000);
        add_cfg(CFG_OUTPUT_MAX, 64'd10000);
        add_cmd(5000, 1000, 1000, 1000, 1'b1, 10000);
        add_cmd(60000, -1000, -1000, -1000, 1'b1, 10000);
        add_cfg(CFG_OUTPUT_MIN, 64'd30000);
        add_cfg(CFG_OUTPUT_MAX, 64'd30000);
        add_cmd(100, 32767, 0, 0, 1'b1, 30000);
        // full output span
        add_cfg(CFG_OUTPUT_MIN, 64'd0);
        add_cfg(CFG_OUTPUT_MAX, 64'd65535);
        add_cmd(65535, -32768, 32767, 32767, 1'b0, 0);
        add_cmd(0, 32767, -32768, -32768, 1'b0, 0);
        add_cfg(CFG_MOTOR_CNT, 64'd1);
        add_cmd(40000, 32767, 0, 0, 1'b1, 65535);
        // zero motors again
        add_cfg(CFG_MOTOR_CNT, 64'd0);
        add_cmd(1, 1, 1, 1, 1'b0, 0);

        set_idling(IDLE_NONE);
        need_drain = 1'b0;
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_CFG) begin
                if (need_drain) drain_block();
                need_drain = 1'b0;
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_command(row.thr, row.yaw, row.pitch, row.roll, row.typed, row.typed_out);
                need_drain = 1'b1;
            end
        end

        // randomized phases, each with its own setting and idling
        for (int ph = 0; ph < 8; ph++) begin
            drain_block();
            ph_cw = $urandom_range(0, 255);
            lo = $urandom_range(0, 30000);
            hi = $urandom_range(lo + 1, 65535);
            case (ph)
                0: begin ph_min = 0; ph_max = U16_MAX; ph_cnt = 8; ph_cw = '0; end
                1: begin ph_min = 0; ph_max = OUTPUT_MAX_RST; ph_cnt = 4; end
                2: begin ph_min = lo; ph_max = hi; ph_cnt = $urandom_range(1, 8); end
                3: begin
                    // min above max
                    ph_max = $urandom_range(0, 40000);
                    ph_min = $urandom_range(int'(ph_max) + 1, 65535);
                    ph_cnt = 6;
                end
                4: begin ph_min = U16_MAX; ph_max = U16_MAX; ph_cnt = 8; ph_cw = '1; end
                5: begin ph_min = lo; ph_max = hi; ph_cnt = $urandom_range(9, 15); end
                6: begin
                    ph_min = $urandom_range(0, 65535);
                    ph_max = $urandom_range(0, 65535);
                    ph_cnt = $urandom_range(0, 15);
                end
                default: begin ph_min = U16_MAX; ph_max = 0; ph_cnt = 1; end
            endcase
            apply_setting(ph_min, ph_max, ph_cnt, rand_table(), rand_table(), ph_cw);
            set_idling(idle_mode_e'(ph % 4));
            for (int k = 0; k < 58; k++) begin
                // hold off until the block has delivered everything
                if (ph == 4 && k % 8 == 7) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                    while (pending_drives.size() != 0) @(posedge i_clk);
                end
                case ($urandom_range(0, 3))
                    0: t = $urandom_range(0, 65535);
                    1: t = int'(ph_min) + int'($urandom_range(0, 400)) - 200;
                    2: t = int'(ph_max) + int'($urandom_range(0, 400)) - 200;
                    default: t = $urandom_range(0, 1) ? 65535 : 0;
                endcase
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                send_command(t[CMD_W-1:0], rand_cmd(), rand_cmd(), rand_cmd(), 1'b0, '0);
            end
        end

        drain_block();
        if (mismatch_cnt == 0 && pending_drives.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
